// ===== hdl/crcfrc_pkg.sv =====
// ----------------------------------------------------------------------------
// crcfrc_pkg
// Shared types, codes and the CRC32C byte update for the record checker.
// ----------------------------------------------------------------------------
package crcfrc_pkg;

  localparam logic [31:0] CRC_POLY     = 32'h82F6_3B78;
  localparam logic [31:0] CRC_INIT     = 32'hFFFF_FFFF;
  localparam int          CFG_IDX_W    = 2;
  localparam int          WORD_BYTES   = 4;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MAGIC       = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_VERSION     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HEADER_SIZE = 2'd2;

  localparam logic [31:0] HEADER_SIZE_RESET = 32'd16;

  // stream status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_TRUNCATED = 2'd1;
  localparam logic [1:0] ST_INVALID   = 2'd2;

  typedef enum logic [4:0] {
    PH_HEADER  = 5'b00001,
    PH_LENGTH  = 5'b00010,
    PH_CHECK   = 5'b00100,
    PH_CONTENT = 5'b01000,
    PH_INVALID = 5'b10000
  } phase_t;

  typedef struct packed {
    logic [63:0] magic_value;
    logic [31:0] expected_version;
    logic [31:0] expected_header_size;
  } cfg_t;

  typedef struct packed {
    logic        record_done;
    logic        record_good;
    logic [31:0] content_length;
    logic [31:0] operation_code;
    logic [31:0] record_number;
    logic        stream_done;
    logic [1:0]  stream_status;
  } result_t;

  // reflected CRC32C, one byte (eight shift steps)
  function automatic logic [31:0] crc32c_byte(input logic [31:0] crc_in,
                                              input logic [7:0]  b);
    logic [31:0] c;
    c = crc_in ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = (c >> 1) ^ (c[0] ? CRC_POLY : 32'd0);
    end
    return c;
  endfunction

endpackage

// ===== hdl/crcfrc_cfg.sv =====
// ----------------------------------------------------------------------------
// crcfrc_cfg
// Configuration register file: magic, version and header size words.
// ----------------------------------------------------------------------------
module crcfrc_cfg (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [crcfrc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [63:0]                       cfg_data,
  output crcfrc_pkg::cfg_t                  cfg
);

  crcfrc_pkg::cfg_t regs;

  assign cfg_ready = 1'b1;
  assign cfg       = regs;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.magic_value          <= 64'd0;
      regs.expected_version     <= 32'd0;
      regs.expected_header_size <= crcfrc_pkg::HEADER_SIZE_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        crcfrc_pkg::REG_MAGIC:       regs.magic_value          <= cfg_data;
        crcfrc_pkg::REG_VERSION:     regs.expected_version     <= cfg_data[31:0];
        crcfrc_pkg::REG_HEADER_SIZE: regs.expected_header_size <= cfg_data[31:0];
        default: ;  // unmapped index: write dropped
      endcase
    end
  end

endmodule

// ===== hdl/crcfrc_parser.sv =====
// ----------------------------------------------------------------------------
// crcfrc_parser
// Header check, record deframing and CRC32C, one byte per beat.
// ----------------------------------------------------------------------------
module crcfrc_parser #(
  parameter int MAGIC_BYTES = 8
) (
  input  logic                    clk,
  input  logic                    rst,
  input  crcfrc_pkg::cfg_t        cfg,
  input  logic                    in_valid,
  input  logic [7:0]              in_byte,
  input  logic                    in_last,
  input  logic                    out_free,
  output logic                    take,
  output logic                    res_valid,
  output crcfrc_pkg::result_t     res
);

  localparam int HDR_LEN = MAGIC_BYTES + 8;

  crcfrc_pkg::phase_t phase, phase_next;
  logic [31:0] pos, pos_next;
  logic [31:0] acc, acc_next;
  logic        mism, mism_next;
  logic [31:0] rec_len, rec_len_next;
  logic [31:0] chk, chk_next;
  logic [31:0] crc, crc_next;
  logic [31:0] op_word, op_word_next;
  logic [31:0] seen, seen_next;

  logic [31:0] acc_or;
  logic [31:0] crc_upd;
  logic [31:0] hdr_rel;
  logic [7:0]  hdr_byte;
  logic        finish;
  logic        good;
  logic        has_result;

  assign acc_or  = acc | ({24'd0, in_byte} << {pos[1:0], 3'b000});
  assign crc_upd = crcfrc_pkg::crc32c_byte(crc, in_byte);
  assign hdr_rel = pos - 32'(MAGIC_BYTES);

  // expected header byte at the current position
  always_comb begin
    if (pos < 32'(MAGIC_BYTES))
      hdr_byte = cfg.magic_value[{pos[2:0], 3'b000} +: 8];
    else if (hdr_rel < 32'd4)
      hdr_byte = cfg.expected_version[{hdr_rel[1:0], 3'b000} +: 8];
    else
      hdr_byte = cfg.expected_header_size[{hdr_rel[1:0], 3'b000} +: 8];
  end

  always_comb begin
    phase_next   = phase;
    pos_next     = pos;
    acc_next     = acc;
    mism_next    = mism;
    rec_len_next = rec_len;
    chk_next     = chk;
    crc_next     = crc;
    op_word_next = op_word;
    seen_next    = seen;
    finish       = 1'b0;
    res          = '0;

    case (phase)
      crcfrc_pkg::PH_HEADER: begin
        if (in_byte != hdr_byte) mism_next = 1'b1;
        pos_next = pos + 32'd1;
        if (pos == 32'(HDR_LEN - 1)) begin
          phase_next = mism_next ? crcfrc_pkg::PH_INVALID : crcfrc_pkg::PH_LENGTH;
          pos_next   = 32'd0;
          acc_next   = 32'd0;
        end
      end
      crcfrc_pkg::PH_LENGTH, crcfrc_pkg::PH_CHECK: begin
        acc_next = acc_or;
        pos_next = pos + 32'd1;
        if (pos == 32'(crcfrc_pkg::WORD_BYTES - 1)) begin
          pos_next = 32'd0;
          acc_next = 32'd0;
          if (phase == crcfrc_pkg::PH_LENGTH) begin
            rec_len_next = acc_or;
            phase_next   = crcfrc_pkg::PH_CHECK;
          end else begin
            chk_next     = acc_or;
            crc_next     = crcfrc_pkg::CRC_INIT;
            op_word_next = 32'd0;
            if (rec_len == 32'd0) finish = 1'b1;   // empty content
            else phase_next = crcfrc_pkg::PH_CONTENT;
          end
        end
      end
      crcfrc_pkg::PH_CONTENT: begin
        crc_next = crc_upd;
        if (pos < 32'(crcfrc_pkg::WORD_BYTES))
          op_word_next[{pos[1:0], 3'b000} +: 8] = in_byte;
        pos_next = pos + 32'd1;
        if (pos_next == rec_len) finish = 1'b1;
      end
      default: ;  // invalid: bytes ignored until stream end
    endcase

    good = finish && (rec_len_next >= 32'd4) && ((~crc_next) == chk_next);

    if (finish) begin
      res.record_done    = 1'b1;
      res.record_good    = good;
      res.content_length = rec_len_next;
      res.operation_code = (rec_len_next >= 32'd4) ? op_word_next : 32'd0;
      res.record_number  = seen;
      seen_next          = seen + 32'd1;
      phase_next         = good ? crcfrc_pkg::PH_LENGTH : crcfrc_pkg::PH_INVALID;
      pos_next           = 32'd0;
      acc_next           = 32'd0;
    end

    if (in_last) begin
      res.stream_done = 1'b1;
      if (phase_next == crcfrc_pkg::PH_LENGTH)
        res.stream_status = (pos_next == 32'd0) ? crcfrc_pkg::ST_OK
                                                : crcfrc_pkg::ST_TRUNCATED;
      else if (phase_next == crcfrc_pkg::PH_CHECK ||
               phase_next == crcfrc_pkg::PH_CONTENT)
        res.stream_status = crcfrc_pkg::ST_TRUNCATED;
      else
        res.stream_status = crcfrc_pkg::ST_INVALID;
      // new stream starts from scratch
      phase_next   = crcfrc_pkg::PH_HEADER;
      pos_next     = 32'd0;
      acc_next     = 32'd0;
      mism_next    = 1'b0;
      rec_len_next = 32'd0;
      chk_next     = 32'd0;
      crc_next     = crcfrc_pkg::CRC_INIT;
      op_word_next = 32'd0;
      seen_next    = 32'd0;
    end
  end

  assign has_result = finish || in_last;
  // a beat with no result never waits for the output slot
  assign take       = in_valid && (out_free || !has_result);
  assign res_valid  = take && has_result;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase   <= crcfrc_pkg::PH_HEADER;
      pos     <= 32'd0;
      acc     <= 32'd0;
      mism    <= 1'b0;
      rec_len <= 32'd0;
      chk     <= 32'd0;
      crc     <= crcfrc_pkg::CRC_INIT;
      op_word <= 32'd0;
      seen    <= 32'd0;
    end else if (take) begin
      phase   <= phase_next;
      pos     <= pos_next;
      acc     <= acc_next;
      mism    <= mism_next;
      rec_len <= rec_len_next;
      chk     <= chk_next;
      crc     <= crc_next;
      op_word <= op_word_next;
      seen    <= seen_next;
    end
  end

  a_invalid_no_record: assert property (@(posedge clk) disable iff (rst)
    take && phase == crcfrc_pkg::PH_INVALID |-> !res.record_done)
    else $error("record completed in invalid phase");

  a_good_needs_done: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.record_good |-> res.record_done && res.content_length >= 32'd4)
    else $error("good flag without a complete record");

  a_status_only_at_end: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res.stream_done |-> res.stream_status == crcfrc_pkg::ST_OK)
    else $error("status set without stream end");

  a_restart_after_end: assert property (@(posedge clk) disable iff (rst)
    take && in_last |=> phase == crcfrc_pkg::PH_HEADER && pos == 32'd0 && seen == 32'd0)
    else $error("state not cleared after stream end");

endmodule

// ===== hdl/crcfrc_out_reg.sv =====
// ----------------------------------------------------------------------------
// crcfrc_out_reg
// Result register driving the master-side stream.
// ----------------------------------------------------------------------------
module crcfrc_out_reg (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  load,
  input  crcfrc_pkg::result_t   res,
  output logic                  free,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [95:0]           m_tdata,   // content_length, operation_code, record_number
  output logic [3:0]            m_tuser,   // record_done, record_good, stream_status[1:0]
  output logic                  m_tlast    // stream_done
);

  crcfrc_pkg::result_t held;

  assign free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (free) begin
      m_tvalid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (free && load) begin
      held <= res;
    end
  end

  assign m_tdata = {held.record_number, held.operation_code, held.content_length};
  assign m_tuser = {held.stream_status, held.record_good, held.record_done};
  assign m_tlast = held.stream_done;

endmodule

// ===== hdl/crc_framed_record_checker.sv =====
// ----------------------------------------------------------------------------
// crc_framed_record_checker
// Journal stream deframer: header check, record framing and CRC32C check.
// ----------------------------------------------------------------------------
// Usage:
//   s_* : journal bytes, one per beat, s_tlast on the final byte of a stream.
//   m_* : one beat per finished record and/or stream end. tuser carries
//         record_done, record_good and the stream status; tlast marks the
//         beat that closes the stream.
//   cfg_*: register writes (magic, version, header size), taken every cycle;
//         write only while no stream byte is in flight.
// Timing: a byte is captured in the input register from its s_* beat, parsed
//   combinationally out of it, and its result is registered in the result
//   register, which drives m_tvalid. One byte per cycle sustained while
//   m_tready does not stall results; the CRC32C byte update is combinational.
// Bytes that produce no result never wait on m_tready. When the receiver
//   stalls, the input register and the result register each hold one beat,
//   after which s_tready drops.
// Reset clears the parser to the header phase, empties both registers and
//   restores the configuration defaults (header size 16).
// ----------------------------------------------------------------------------
module crc_framed_record_checker #(
  parameter int MAGIC_BYTES = 8
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [7:0]                        s_tdata,   // data_byte
  input  logic                              s_tlast,   // stream_last
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [95:0]                       m_tdata,   // content_length, operation_code,
                                                       // record_number
  output logic [3:0]                        m_tuser,   // record_done, record_good,
                                                       // stream_status[1:0]
  output logic                              m_tlast,   // stream_done
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [crcfrc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [63:0]                       cfg_data
);

  crcfrc_pkg::cfg_t    cfg;
  crcfrc_pkg::result_t res;
  logic                in_valid;
  logic [7:0]          in_byte;
  logic                in_last;
  logic                take;
  logic                res_valid;
  logic                out_free;

  crcfrc_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  assign s_tready = !in_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_byte <= s_tdata;
      in_last <= s_tlast;
    end
  end

  crcfrc_parser #(
    .MAGIC_BYTES (MAGIC_BYTES)
  ) u_parser (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_byte   (in_byte),
    .in_last   (in_last),
    .out_free  (out_free),
    .take      (take),
    .res_valid (res_valid),
    .res       (res)
  );

  crcfrc_out_reg u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (res_valid),
    .res      (res),
    .free     (out_free),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule
